FILE: rtl/core/weighted_link_swap_engine_core_assert.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef WEIGHTED_LINK_SWAP_ENGINE_CORE_ASSERT_SVH
`define WEIGHTED_LINK_SWAP_ENGINE_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define WLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/wlse_pkg.sv
// Package for the weighted link swap engine: payload types, function codes.
// No dependencies.
package wlse_pkg;
  localparam logic [2:0] FN_WR_BIT    = 3'd0;
  localparam logic [2:0] FN_WR_PROB   = 3'd1;
  localparam logic [2:0] FN_WR_SLINK  = 3'd2;
  localparam logic [2:0] FN_WR_DLINK  = 3'd3;
  localparam logic [2:0] FN_SWAP_S    = 3'd4;
  localparam logic [2:0] FN_SWAP_D    = 3'd5;
  localparam logic [2:0] FN_RD_BIT    = 3'd6;
  localparam logic [2:0] FN_CLR_CNT   = 3'd7;

  localparam logic [1:0] RULE_NEW = 2'd0;
  localparam logic [1:0] RULE_OLD = 2'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [16:0] value;
    logic [7:0]  link_first;
    logic [7:0]  link_second;
    logic        end_first;
    logic        end_second;
    logic [15:0] draw;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] swap_total;
    logic        read_bit;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic ld_req;    // capture request
    logic rd_links;  // issue link reads
    logic cap_links; // capture link words
    logic rd_pq;     // issue prob/adjacency reads, index k
    logic cap_pq;    // capture prob/adjacency data, index k
    logic [1:0] k;
    logic mul0;      // first product
    logic mul1;      // second product
    logic decide;    // compute verdict
    logic wr_adj;    // adjacency write, index w
    logic [2:0] w;
    logic wr_link;   // link write-back
    logic finish;    // emit result
    logic simple;    // simple write/read op
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ok;    // swap passes all checks and changes the matrix
    logic       nwr;   // number of adjacency writes is 8 (double) vs 4
  } sts_t;
endpackage

FILE: rtl/core/weighted_link_swap_engine_core.sv
// Swap: dispatch, link reads, four prob/adjacency reads, two products, verdict, and if
// the matrix changes four matrix writes (eight if double) and link write-back; loads and
// bit reads (via a capture) go to the result. Single-port memories read a word per cycle.
// One item at a time; busy is high after acceptance through the result cycle.
// Result shows for one cycle on done; the receiver cannot stall it.
// Reset clears the controller, the counter and rule_q; memories are undefined.
module weighted_link_swap_engine_core #(
  parameter int NODES      = 64,
  parameter int LINK_SLOTS = 256,
  parameter int PROB_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wlse_pkg::req_t req_i,
  output logic           done,
  output wlse_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_data_i
);
  logic [1:0]     rule_q;
  wlse_pkg::cmd_t cmd;
  wlse_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rule_q <= wlse_pkg::RULE_NEW;
    else if (cfg_valid_i) rule_q <= cfg_data_i;
  end

  wlse_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts),
    .busy_o(busy), .done_o(done), .cmd_o(cmd));

  wlse_datapath #(.NODES(NODES), .LINK_SLOTS(LINK_SLOTS), .PROB_BITS(PROB_BITS)) u_dp (
    .clk_i, .rst_ni, .req_i, .rule_i(rule_q), .cmd_i(cmd), .sts_o(sts), .rsp_o);
endmodule

FILE: rtl/core/wlse_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module wlse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/core/wlse_datapath.sv
// Datapath: link lists, probability table, adjacency matrix, weight and counter.
// Depends on wlse_pkg and wlse_ram.
module wlse_datapath #(
  parameter int NODES      = 64,
  parameter int LINK_SLOTS = 256,
  parameter int PROB_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wlse_pkg::req_t req_i,
  input  logic [1:0]     rule_i,
  input  wlse_pkg::cmd_t cmd_i,
  output wlse_pkg::sts_t sts_o,
  output wlse_pkg::rsp_t rsp_o
);
  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(LINK_SLOTS);
  localparam int CW = 2 * NW;
  localparam int PW = PROB_BITS + 1;
  localparam logic [PW-1:0] OneP = PW'(1) << PROB_BITS;

  wlse_pkg::req_t r_q;
  logic [NW-1:0] na, nb;
  logic [SW-1:0] s1, s2;

  // link endpoints: a = first/fixed, b = second/other
  logic [NW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic [PW-1:0] p_q [4];
  logic          x_q [4];
  logic [2*PW-1:0] m_q;
  logic [2*PW:0]   acc_q;
  logic [15:0]   cnt_q;
  logic          ok_q, acc_bit_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) r_q <= req_i;
  end
  assign na = NW'(r_q.node_a % NODES);
  assign nb = NW'(r_q.node_b % NODES);
  assign s1 = SW'(r_q.link_first % LINK_SLOTS);
  assign s2 = SW'(r_q.link_second % LINK_SLOTS);
  logic dbl;
  assign dbl = (r_q.func == wlse_pkg::FN_SWAP_D);

  // link memories, port used for slot 1 and slot 2 alternately
  logic sl_we, dl_we;
  logic [SW-1:0] l_addr;
  logic [CW-1:0] l_wd, sl_rd, dl_rd;
  logic l_ph_q; // 1 -> slot1 word on the read port while capturing

  // link phases: rd_links issues addr s1, then the first cap_links issues addr s2
  always_comb begin
    l_addr = l_ph_q ? s2 : s1;
    l_wd   = {na, nb};
    sl_we  = 1'b0;
    dl_we  = 1'b0;
    if (cmd_i.simple && r_q.func == wlse_pkg::FN_WR_SLINK) begin
      sl_we = 1'b1; l_addr = s1;
    end
    if (cmd_i.simple && r_q.func == wlse_pkg::FN_WR_DLINK) begin
      dl_we = 1'b1; l_addr = s1;
    end
    if (cmd_i.wr_link) begin
      l_addr = cmd_i.w[0] ? s2 : s1;
      if (!dbl) begin
        sl_we = 1'b1;
        l_wd  = cmd_i.w[0] ? {a2_q, b1_q} : {a1_q, b2_q};
      end else begin
        dl_we = 1'b1;
        if (!cmd_i.w[0])
          l_wd = r_q.end_first ? {b1_q, a2_q} : {a2_q, b1_q};
        else
          l_wd = r_q.end_second ? {b2_q, a1_q} : {a1_q, b2_q};
      end
    end
  end

  wlse_ram #(.Width(CW), .Depth(LINK_SLOTS)) u_slinks (
    .clk_i, .we_i(sl_we), .addr_i(l_addr), .wdata_i(l_wd), .rdata_o(sl_rd));
  wlse_ram #(.Width(CW), .Depth(LINK_SLOTS)) u_dlinks (
    .clk_i, .we_i(dl_we), .addr_i(l_addr), .wdata_i(l_wd), .rdata_o(dl_rd));

  logic [CW-1:0] lrd;
  logic [NW-1:0] fx, ot;
  logic          ef;
  assign lrd = dbl ? dl_rd : sl_rd;
  assign ef  = l_ph_q ? r_q.end_first : r_q.end_second;
  always_comb begin
    fx = lrd[CW-1:NW];
    ot = lrd[NW-1:0];
    if (dbl && ef) begin
      fx = lrd[NW-1:0];
      ot = lrd[CW-1:NW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l_ph_q <= 1'b0;
    else if (cmd_i.rd_links) l_ph_q <= ~l_ph_q;
    else if (cmd_i.cap_links) l_ph_q <= ~l_ph_q;
    else l_ph_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_links) begin
      if (l_ph_q) begin
        a1_q <= fx; b1_q <= ot;
      end else begin
        a2_q <= fx; b2_q <= ot;
      end
    end
  end

  // cell pairs for probability/adjacency lookups, index k:
  // k0 (a1,b2)/(a2,b1)  k1 (a1,b1)/(a1,b2)  k2 (a2,b1)/(b1,a2)  k3 (a2,b2)/(b2,a1)
  logic [NW-1:0] pr, pc, xr, xc;
  always_comb begin
    case (cmd_i.k)
      2'd0: begin pr = a1_q; pc = b2_q; xr = a2_q; xc = b1_q; end
      2'd1: begin pr = a1_q; pc = b1_q; xr = a1_q; xc = b2_q; end
      2'd2: begin pr = a2_q; pc = b1_q; xr = b1_q; xc = a2_q; end
      default: begin pr = a2_q; pc = b2_q; xr = b2_q; xc = a1_q; end
    endcase
  end

  // adjacency write sequence; single: set,clear,set,clear; double: sets then clears
  logic [NW-1:0] wr, wc;
  logic          wv;
  always_comb begin
    wr = a1_q; wc = b2_q; wv = 1'b1;
    if (!dbl) begin
      case (cmd_i.w[1:0])
        2'd0: begin wr = a1_q; wc = b2_q; wv = 1'b1; end
        2'd1: begin wr = a1_q; wc = b1_q; wv = 1'b0; end
        2'd2: begin wr = a2_q; wc = b1_q; wv = 1'b1; end
        default: begin wr = a2_q; wc = b2_q; wv = 1'b0; end
      endcase
    end else begin
      case (cmd_i.w)
        3'd0: begin wr = a2_q; wc = b1_q; wv = 1'b1; end
        3'd1: begin wr = a1_q; wc = b2_q; wv = 1'b1; end
        3'd2: begin wr = b1_q; wc = a2_q; wv = 1'b1; end
        3'd3: begin wr = b2_q; wc = a1_q; wv = 1'b1; end
        3'd4: begin wr = a1_q; wc = b1_q; wv = 1'b0; end
        3'd5: begin wr = b1_q; wc = a1_q; wv = 1'b0; end
        3'd6: begin wr = a2_q; wc = b2_q; wv = 1'b0; end
        default: begin wr = b2_q; wc = a2_q; wv = 1'b0; end
      endcase
    end
  end

  logic          p_we, x_we, x_wd;
  logic [CW-1:0] p_addr, x_addr;
  logic [PW-1:0] p_wd, p_rd;
  logic          x_rd;
  always_comb begin
    p_we   = cmd_i.simple && r_q.func == wlse_pkg::FN_WR_PROB;
    p_wd   = (32'(r_q.value) > 32'(OneP)) ? OneP : PW'(r_q.value);
    p_addr = cmd_i.simple ? {na, nb} : {pr, pc};
    x_we   = 1'b0;
    x_wd   = r_q.value[0];
    x_addr = {xr, xc};
    if (cmd_i.simple) begin
      x_addr = {na, nb};
      x_we   = (r_q.func == wlse_pkg::FN_WR_BIT);
    end
    if (cmd_i.wr_adj) begin
      x_addr = {wr, wc};
      x_we   = 1'b1;
      x_wd   = wv;
    end
  end

  wlse_ram #(.Width(PW), .Depth(NODES * NODES)) u_prob (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wd), .rdata_o(p_rd));
  wlse_ram #(.Width(1), .Depth(NODES * NODES)) u_adj (
    .clk_i, .we_i(x_we), .addr_i(x_addr), .wdata_i(x_wd), .rdata_o(x_rd));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pq) begin
      p_q[cmd_i.k] <= p_rd;
      x_q[cmd_i.k] <= x_rd;
    end
  end

  // weight: p11=p_q0 p12=p_q1 p21=p_q2 p22=p_q3
  logic [PW-1:0] ma, mb;
  always_comb begin
    if (rule_i == wlse_pkg::RULE_NEW) begin
      ma = cmd_i.mul1 ? p_q[2] : p_q[0];
      mb = cmd_i.mul1 ? OneP : p_q[2];
    end else if (rule_i == wlse_pkg::RULE_OLD) begin
      ma = OneP - p_q[1];
      mb = OneP - p_q[3];
    end else begin
      ma = cmd_i.mul1 ? p_q[2] : p_q[0];
      mb = cmd_i.mul1 ? OneP - p_q[3] : OneP - p_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul0 || cmd_i.mul1) m_q <= ma * mb;
    if (cmd_i.mul1) acc_q <= {1'b0, m_q};
  end

  logic [2*PW:0]  wsum;
  logic [2*PW:0]  wgt;
  logic [PW+15:0] dsc;
  assign wsum = acc_q + {1'b0, m_q};
  always_comb begin
    if (rule_i == wlse_pkg::RULE_NEW || rule_i == wlse_pkg::RULE_OLD)
      wgt = acc_q >> PROB_BITS;
    else
      wgt = wsum >> (PROB_BITS + 1);
  end
  always_comb begin
    if (PROB_BITS >= 16) dsc = (PW + 16)'(r_q.draw) << (PROB_BITS - 16);
    else                 dsc = (PW + 16)'(r_q.draw) >> (16 - PROB_BITS);
  end

  logic pass, same, noch, bad, conf, chg;
  always_comb begin
    same = (s1 == s2);
    pass = !same && ((2 * PW + 1)'(dsc) < wgt);
    conf = x_q[0] | x_q[1] | x_q[2] | x_q[3];
    if (!dbl) begin
      noch = (a1_q == a2_q) || (b1_q == b2_q);
      bad  = (a1_q == b2_q) || (a2_q == b1_q) || conf;
    end else begin
      noch = (a1_q == a2_q);
      bad  = conf || (a1_q == b2_q) || (a2_q == b1_q);
    end
    chg = pass && !noch && !bad;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      ok_q      <= chg;
      acc_bit_q <= pass && (noch || !bad);
    end
    if (cmd_i.cap_pq) rb_q <= x_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.finish) begin
      if (r_q.func == wlse_pkg::FN_CLR_CNT) cnt_q <= '0;
      else if (acc_bit_q && (r_q.func == wlse_pkg::FN_SWAP_S || dbl) && cnt_q != 16'hFFFF)
        cnt_q <= cnt_q + 16'd1;
    end
  end

  logic isswap;
  assign isswap = (r_q.func == wlse_pkg::FN_SWAP_S) || dbl;
  always_comb begin
    rsp_o.accepted   = isswap && acc_bit_q;
    rsp_o.swap_total = cnt_q;
    rsp_o.read_bit   = (r_q.func == wlse_pkg::FN_RD_BIT) && rb_q;
    if (r_q.func == wlse_pkg::FN_CLR_CNT) rsp_o.swap_total = '0;
    else if (isswap && acc_bit_q && cnt_q != 16'hFFFF) rsp_o.swap_total = cnt_q + 16'd1;
  end

  assign sts_o.func = r_q.func;
  assign sts_o.ok   = ok_q;
  assign sts_o.nwr  = dbl;
endmodule

FILE: rtl/core/wlse_ctrl.sv
// Controller FSM sequencing memory reads, products, verdict and write-back.
// Depends on wlse_pkg.
module wlse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wlse_pkg::sts_t sts_i,
  output logic           busy_o,
  output logic           done_o,
  output wlse_pkg::cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_L0    = 4'd3;
  localparam logic [3:0] S_L1    = 4'd4;
  localparam logic [3:0] S_L2    = 4'd5;
  localparam logic [3:0] S_PQ    = 4'd6;
  localparam logic [3:0] S_PQC   = 4'd7;
  localparam logic [3:0] S_M0    = 4'd8;
  localparam logic [3:0] S_M1    = 4'd9;
  localparam logic [3:0] S_DEC   = 4'd10;
  localparam logic [3:0] S_WADJ  = 4'd11;
  localparam logic [3:0] S_WL    = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] st_q, st_d;
  logic [2:0] c_q, c_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      c_q  <= '0;
    end else begin
      st_q <= st_d;
      c_q  <= c_d;
    end
  end

  always_comb begin
    st_d   = st_q;
    c_d    = c_q;
    cmd_o  = '0;
    cmd_o.k = c_q[1:0];
    cmd_o.w = c_q;
    done_o = 1'b0;
    busy_o = (st_q != S_IDLE);
    case (st_q)
      S_IDLE: begin
        cmd_o.ld_req = start_i;
        if (start_i) st_d = S_DISP;
      end
      S_DISP: begin
        c_d = '0;
        if (sts_i.func == wlse_pkg::FN_SWAP_S || sts_i.func == wlse_pkg::FN_SWAP_D) begin
          st_d = S_L0;
        end else begin
          cmd_o.simple = 1'b1;  // writes land here; reads issue
          st_d = (sts_i.func == wlse_pkg::FN_RD_BIT) ? S_RDB : S_DONE;
        end
      end
      S_RDB: begin
        cmd_o.cap_pq = 1'b1;
        cmd_o.k = 2'd0;
        st_d = S_DONE;
      end
      S_L0: begin cmd_o.rd_links = 1'b1; st_d = S_L1; end
      S_L1: begin cmd_o.cap_links = 1'b1; st_d = S_L2; end
      S_L2: begin cmd_o.cap_links = 1'b1; st_d = S_PQ; end
      S_PQ: begin cmd_o.rd_pq = 1'b1; st_d = S_PQC; end
      S_PQC: begin
        cmd_o.cap_pq = 1'b1;
        c_d = c_q + 3'd1;
        st_d = (c_q[1:0] == 2'd3) ? S_M0 : S_PQ;
      end
      S_M0: begin cmd_o.mul0 = 1'b1; st_d = S_M1; end
      S_M1: begin cmd_o.mul1 = 1'b1; st_d = S_DEC; end
      S_DEC: begin cmd_o.decide = 1'b1; c_d = '0; st_d = S_WADJ; end
      S_WADJ: begin
        if (!sts_i.ok) st_d = S_DONE;
        else begin
          cmd_o.wr_adj = 1'b1;
          c_d = c_q + 3'd1;
          if ((sts_i.nwr && c_q == 3'd7) || (!sts_i.nwr && c_q == 3'd3)) begin
            c_d = '0;
            st_d = S_WL;
          end
        end
      end
      S_WL: begin
        cmd_o.wr_link = 1'b1;
        c_d = c_q + 3'd1;
        if (c_q[0]) st_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        done_o = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/core/wlse_checker.sv
// Port-level checker for the swap engine, bound to the top level.
// Depends on wlse_pkg and the assertion macro header.
`include "weighted_link_swap_engine_core_assert.svh"
module wlse_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done,
  input wlse_pkg::rsp_t rsp_o
);
  `WLS_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `WLS_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done, busy)
  `WLS_ASSERT_NXT(a_done_frees, clk_i, rst_ni, done, !busy)
  `WLS_ASSERT_IMP(a_acc_cnt, clk_i, rst_ni, done && rsp_o.accepted, rsp_o.swap_total != 16'd0)
endmodule

bind weighted_link_swap_engine_core wlse_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done, .rsp_o);

FILE: sim/tb_weighted_link_swap_engine_core.sv
// Testbench for weighted_link_swap_engine_core: a queue-fed driver, a strobe monitor and
// an in-bench predictor of matrix, probability, link and counter state.
// Depends on wlse_pkg and the core RTL.
module tb_weighted_link_swap_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [16:0] PROB_ONE = 17'h10000;

  logic clk_i, rst_ni;
  logic start, busy, done;
  wlse_pkg::req_t req;
  wlse_pkg::rsp_t rsp_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_data_i;

  weighted_link_swap_engine_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req),
    .done(done), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  bit          adj_m [4096];
  logic [16:0] prob_m [4096];
  logic [5:0]  slink_m [256][2];
  logic [5:0]  dlink_m [256][2];
  logic [15:0] count_m;
  logic [1:0]  rule_m;

  wlse_pkg::req_t item_q[$];
  wlse_pkg::rsp_t pending_rsp[$];
  int   fails;
  int   gap;
  bit   burst;
  int   idle_cycles;

  function automatic logic [11:0] cell_at(logic [5:0] r, logic [5:0] c);
    return {r, c};
  endfunction

  function automatic longint unsigned accept_weight(longint unsigned p11, longint unsigned p12,
                                                    longint unsigned p21, longint unsigned p22);
    longint unsigned one;
    one = 64'h10000;
    if (rule_m == wlse_pkg::RULE_NEW) return (p11 * p21) >> 16;
    if (rule_m == wlse_pkg::RULE_OLD) return ((one - p12) * (one - p22)) >> 16;
    return (p11 * (one - p12) + p21 * (one - p22)) >> 17;
  endfunction

  function automatic bit single_swap_ok(logic [7:0] s1, logic [7:0] s2, logic [15:0] d);
    logic [5:0] a1, b1, a2, b2;
    longint unsigned w;
    a1 = slink_m[s1][0]; b1 = slink_m[s1][1];
    a2 = slink_m[s2][0]; b2 = slink_m[s2][1];
    w = accept_weight(prob_m[cell_at(a1, b2)], prob_m[cell_at(a1, b1)],
                      prob_m[cell_at(a2, b1)], prob_m[cell_at(a2, b2)]);
    if (s1 == s2 || d >= w) return 0;
    if (a1 == a2 || b1 == b2) return 1;   // no-op swap still counts
    if (a1 == b2 || a2 == b1) return 0;
    if (adj_m[cell_at(a1, b2)] || adj_m[cell_at(a2, b1)] || adj_m[cell_at(b2, a1)] ||
        adj_m[cell_at(b1, a2)]) return 0;
    adj_m[cell_at(a1, b2)] = 1; adj_m[cell_at(a1, b1)] = 0;
    adj_m[cell_at(a2, b1)] = 1; adj_m[cell_at(a2, b2)] = 0;
    slink_m[s1][1] = b2; slink_m[s2][1] = b1;
    return 1;
  endfunction

  function automatic bit double_swap_ok(logic [7:0] s1, logic [7:0] s2, bit e1, bit e2,
                                        logic [15:0] d);
    logic [5:0] f1, o1, f2, o2;
    longint unsigned w;
    f1 = dlink_m[s1][e1]; o1 = dlink_m[s1][!e1];
    f2 = dlink_m[s2][e2]; o2 = dlink_m[s2][!e2];
    w = accept_weight(prob_m[cell_at(f1, o2)], prob_m[cell_at(f1, o1)],
                      prob_m[cell_at(f2, o1)], prob_m[cell_at(f2, o2)]);
    if (s1 == s2 || d >= w) return 0;
    if (f1 == f2) return 1;
    if (adj_m[cell_at(f2, o1)] || adj_m[cell_at(f1, o2)] || adj_m[cell_at(o1, f2)] ||
        adj_m[cell_at(o2, f1)]) return 0;
    if (f1 == o2 || f2 == o1) return 0;
    // sets first, then clears
    adj_m[cell_at(f2, o1)] = 1; adj_m[cell_at(f1, o2)] = 1;
    adj_m[cell_at(o1, f2)] = 1; adj_m[cell_at(o2, f1)] = 1;
    adj_m[cell_at(f1, o1)] = 0; adj_m[cell_at(o1, f1)] = 0;
    adj_m[cell_at(f2, o2)] = 0; adj_m[cell_at(o2, f2)] = 0;
    dlink_m[s1][e1] = f2; dlink_m[s2][e2] = f1;
    return 1;
  endfunction

  function automatic wlse_pkg::rsp_t engine_response(wlse_pkg::req_t r);
    wlse_pkg::rsp_t o;
    o = '0;
    case (r.func)
      wlse_pkg::FN_WR_BIT:   adj_m[cell_at(r.node_a, r.node_b)] = r.value[0];
      wlse_pkg::FN_WR_PROB:
        prob_m[cell_at(r.node_a, r.node_b)] = (r.value > PROB_ONE) ? PROB_ONE : r.value;
      wlse_pkg::FN_WR_SLINK: begin
        slink_m[r.link_first][0] = r.node_a; slink_m[r.link_first][1] = r.node_b;
      end
      wlse_pkg::FN_WR_DLINK: begin
        dlink_m[r.link_first][0] = r.node_a; dlink_m[r.link_first][1] = r.node_b;
      end
      wlse_pkg::FN_SWAP_S:
        o.accepted = single_swap_ok(r.link_first, r.link_second, r.draw);
      wlse_pkg::FN_SWAP_D:
        o.accepted = double_swap_ok(r.link_first, r.link_second, r.end_first,
                                    r.end_second, r.draw);
      wlse_pkg::FN_RD_BIT:   o.read_bit = adj_m[cell_at(r.node_a, r.node_b)];
      default:               count_m = '0;
    endcase
    if (o.accepted && count_m != 16'hFFFF) count_m++;
    o.swap_total = count_m;
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
      gap   = 0;
    end else begin
      if (start && !busy) begin
        pending_rsp.push_back(engine_response(req));
        void'(item_q.pop_front());
        gap = burst ? 0 : $urandom_range(0, 3);
      end else if (!start && gap != 0) begin
        gap--;
      end
      if (start && busy) begin
        // hold the beat
      end else if (gap == 0 && item_q.size() != 0) begin
        start <= 1'b1;
        req   <= item_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, rsp_o);
        fails++;
      end else begin
        if (rsp_o.accepted !== pending_rsp[0].accepted)
          $display("%0t: accepted expected %0d actual %0d", $realtime,
                   pending_rsp[0].accepted, rsp_o.accepted);
        if (rsp_o.swap_total !== pending_rsp[0].swap_total)
          $display("%0t: swap_total expected %0d actual %0d", $realtime,
                   pending_rsp[0].swap_total, rsp_o.swap_total);
        if (rsp_o.read_bit !== pending_rsp[0].read_bit)
          $display("%0t: read_bit expected %0d actual %0d", $realtime,
                   pending_rsp[0].read_bit, rsp_o.read_bit);
        if (rsp_o !== pending_rsp[0]) fails++;
        void'(pending_rsp.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("weighted_link_swap_engine_core verification failed");
      $finish;
    end
  end

  // stimulus side bookkeeping, ahead of execution
  logic [5:0] node_set [8] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd21, 6'd42, 6'd62, 6'd63};
  logic [1:0] rule_seq [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
  bit adj_known [4096];
  bit s_safe [256];
  bit d_safe [256];

  function automatic logic [5:0] pick_node();
    return node_set[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] pick_slot(bit dbl);
    logic [7:0] s;
    do s = $urandom_range(0, 255); while (!(dbl ? d_safe[s] : s_safe[s]));
    return s;
  endfunction

  function automatic wlse_pkg::req_t noise_req(logic [2:0] fn);
    wlse_pkg::req_t r;
    r = {$urandom, $urandom, $urandom};
    r.func = fn;
    return r;
  endfunction

  function automatic logic [16:0] prob_value();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 131071);
      1:       return $urandom_range(0, 20000);
      default: return $urandom_range(40000, 65536);
    endcase
  endfunction

  task automatic add_link(bit dbl, logic [7:0] slot, logic [5:0] na, logic [5:0] nb);
    wlse_pkg::req_t r;
    r = noise_req(dbl ? wlse_pkg::FN_WR_DLINK : wlse_pkg::FN_WR_SLINK);
    r.link_first = slot; r.node_a = na; r.node_b = nb;
    item_q.push_back(r);
    if (dbl) d_safe[slot] = 1; else s_safe[slot] = 1;
  endtask

  task automatic add_swap(bit dbl, logic [7:0] s1, logic [7:0] s2, logic [15:0] d);
    wlse_pkg::req_t r;
    r = noise_req(dbl ? wlse_pkg::FN_SWAP_D : wlse_pkg::FN_SWAP_S);
    r.link_first = s1; r.link_second = s2; r.draw = d;
    item_q.push_back(r);
  endtask

  task automatic add_cell(logic [2:0] fn, logic [5:0] na, logic [5:0] nb, logic [16:0] v);
    wlse_pkg::req_t r;
    r = noise_req(fn);
    r.node_a = na; r.node_b = nb; r.value = v;
    item_q.push_back(r);
    if (fn == wlse_pkg::FN_WR_BIT) adj_known[{na, nb}] = 1;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (item_q.size() != 0 || pending_rsp.size() != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rule(logic [1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    rule_m = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    wlse_pkg::req_t r;
    int pick;
    logic [5:0] na, nb;
    bit zero_ok;
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        zero_ok = pick[0] ? d_safe[0] : s_safe[0];
        add_swap(pick[0], pick_slot(pick[0]),
                 ($urandom_range(0, 15) == 0 && zero_ok) ? 8'd0 : pick_slot(pick[0]),
                 $urandom);
        if ($urandom_range(0, 15) == 0) item_q[$].link_second = item_q[$].link_first;
      end else if (pick < 72) begin
        add_link(pick[0], $urandom_range(0, 255), pick_node(), pick_node());
      end else if (pick < 80) begin
        add_cell(wlse_pkg::FN_WR_PROB, pick_node(), pick_node(), prob_value());
      end else if (pick < 85) begin
        add_cell(wlse_pkg::FN_WR_BIT, pick_node(), pick_node(), $urandom_range(0, 131071));
      end else if (pick < 89) begin
        add_cell(pick[0] ? wlse_pkg::FN_WR_BIT : wlse_pkg::FN_WR_PROB,
                 $urandom, $urandom, $urandom);
      end else if (pick < 96) begin
        do begin na = $urandom; nb = $urandom; end while (!adj_known[{na, nb}]);
        add_cell(wlse_pkg::FN_RD_BIT, na, nb, $urandom);
      end else if (pick < 98) begin
        item_q.push_back(noise_req(wlse_pkg::FN_CLR_CNT));
      end else begin
        // link to random nodes, possibly outside the loaded set; slot is off limits for swaps afterwards
        r = noise_req(pick[0] ? wlse_pkg::FN_WR_DLINK : wlse_pkg::FN_WR_SLINK);
        item_q.push_back(r);
        if (pick[0]) d_safe[r.link_first] = 0; else s_safe[r.link_first] = 0;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    fails = 0;
    burst = 0;
    count_m = '0;
    rule_m = wlse_pkg::RULE_NEW;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // load every matrix bit and probability among the working node set
    foreach (node_set[i]) foreach (node_set[j]) begin
      add_cell(wlse_pkg::FN_WR_PROB, node_set[i], node_set[j], prob_value());
      add_cell(wlse_pkg::FN_WR_BIT, node_set[i], node_set[j], {$urandom_range(0, 65535),
               $urandom_range(0, 3) == 0});
    end
    for (int s = 0; s < 12; s++) begin
      add_link(0, (s == 11) ? 8'd255 : 8'(s), pick_node(), pick_node());
      add_link(1, (s == 11) ? 8'd255 : 8'(s), pick_node(), pick_node());
    end

    // directed corners: saturating probability, draw extremes, equal slots,
    // shared endpoints, read-back, counter clear
    add_cell(wlse_pkg::FN_WR_PROB, 6'd63, 6'd63, 17'h1FFFF);
    add_cell(wlse_pkg::FN_WR_PROB, 6'd0, 6'd63, 17'h10000);
    add_link(0, 8'd1, 6'd0, 6'd63);
    add_link(0, 8'd2, 6'd0, 6'd1);
    add_swap(0, 8'd1, 8'd2, 16'd0);
    add_swap(0, 8'd1, 8'd1, 16'd0);
    add_link(0, 8'd3, 6'd63, 6'd0);
    add_swap(0, 8'd1, 8'd3, 16'hFFFF);
    add_swap(0, 8'd3, 8'd1, 16'd0);
    add_link(1, 8'd1, 6'd2, 6'd3);
    add_link(1, 8'd2, 6'd2, 6'd62);
    add_swap(1, 8'd1, 8'd2, 16'd0);
    add_swap(1, 8'd2, 8'd2, 16'd0);
    add_swap(1, 8'd255, 8'd0, 16'hFFFF);
    add_cell(wlse_pkg::FN_RD_BIT, 6'd63, 6'd63, 17'd0);
    add_cell(wlse_pkg::FN_RD_BIT, 6'd0, 6'd1, 17'h1FFFF);
    item_q.push_back(noise_req(wlse_pkg::FN_CLR_CNT));
    add_swap(0, 8'd255, 8'd0, 16'd0);
    drain();

    // rules in turn, including the unused code; pause until idle before each write
    foreach (rule_seq[k]) begin
      write_rule(rule_seq[k]);
      random_phase(100);
      drain();
    end
    write_rule(2'd2);
    random_phase(60);
    drain();
    repeat (30) @(posedge clk_i);

    if (fails == 0)
      $display("weighted_link_swap_engine_core verification clean");
    else
      $display("weighted_link_swap_engine_core verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/wlse_pkg.sv
rtl/core/wlse_ram.sv
rtl/core/wlse_datapath.sv
rtl/core/wlse_ctrl.sv
rtl/core/weighted_link_swap_engine_core.sv
rtl/core/wlse_checker.sv
sim/tb_weighted_link_swap_engine_core.sv
